// ----- rtl/lfl_pkg.sv -----
// Package for the LFO flanger: widths, codes, state type, sine and saturation functions.
package lfl_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int LFO_W     = 16;
  localparam int PHASE_W   = 32;
  localparam int STEP_W    = 21;
  localparam int MAXD_W    = 10;
  localparam int FB_W      = 16;
  localparam int MIX_W     = 17;
  localparam int WAVE_W    = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 21;

  localparam int OPW   = SAMPLE_W + 1;
  localparam int HI_W  = OPW + 1;
  localparam int SUM_W = OPW + 2;
  localparam int CNT_W = $clog2(MIX_W);

  localparam int BUFFER_LEN_DEF   = 882;
  localparam int SINE_ENTRIES_DEF = 1024;

  localparam logic [FB_W-1:0]  FB_MAX  = 16'd64880;
  localparam logic [MIX_W-1:0] MIX_ONE = 17'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_STEP,
    CFG_MAX_DELAY,
    CFG_FEEDBACK,
    CFG_MIX,
    CFG_WAVEFORM
  } cfg_idx_t;

  typedef enum logic [WAVE_W-1:0] {
    WAVE_SINE,
    WAVE_TRI,
    WAVE_SAW
  } wave_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LFO_IDX,
    ST_LFO_VAL,
    ST_DLY,
    ST_ADDR,
    ST_RD,
    ST_FB,
    ST_WR,
    ST_MIX,
    ST_DONE
  } state_t;

  // sin(2*pi*t/2^32) in Q1.15, odd polynomial per quadrant in Q30
  function automatic logic signed [LFO_W-1:0] sine_of_turn(input logic [PHASE_W-1:0] t);
    logic [63:0] u;
    logic [63:0] u2;
    logic [63:0] p;
    logic [63:0] s;
    logic [LFO_W-1:0] mag;
    u = {34'd0, t[29:0]};
    if (t[30]) begin
      u = (64'd1 << 30) - u;
    end
    u2 = (u * u) >> 30;
    p = 64'd3864;
    p = 64'd172272 - ((p * u2) >> 30);
    p = 64'd5026996 - ((p * u2) >> 30);
    p = 64'd85569306 - ((p * u2) >> 30);
    p = 64'd693598668 - ((p * u2) >> 30);
    p = 64'd1686629713 - ((p * u2) >> 30);
    s = (p * u) >> 30;
    s = (s + 64'd16384) >> 15;
    if (s > 64'd32767) begin
      s = 64'd32767;
    end
    mag = s[LFO_W-1:0];
    return t[31] ? (~mag + 1'b1) : mag;
  endfunction

  function automatic logic [SAMPLE_W-1:0] sat_sample(input logic [SUM_W-1:0] v);
    logic [SUM_W-SAMPLE_W:0] top;
    top = v[SUM_W-1:SAMPLE_W-1];
    if ((&top) || (~|top)) begin
      return v[SAMPLE_W-1:0];
    end
    return v[SUM_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
  endfunction

endpackage

// ----- rtl/lfo_flanger.sv -----
// Flanger: LFO-modulated delay line with feedback, bit-serial multiply datapath.
//
// Channels: in_* takes one Q1.23 sample per item (tdata) with a block-start flag
// in tuser that restarts the LFO phase. out_* returns the mixed sample and the
// LFO value used for it. cfg_* writes the five control registers; write them
// only while no item is in flight.
// Items are taken one at a time (in_tready is high only in the idle state);
// each passes the LFO index, LFO value, delay, address, read, feedback, write,
// mix and done states. The shared bit-serial multiplier takes one multiplier
// bit per cycle: 16 bits for the delay, 16 for the feedback gain, 17 for the mix.
// Reset: registers return to defaults (max_delay one, others zero) and a
// clearing pass zeroes every entry of the delay ring, one entry per cycle,
// with in_tready low. Configuration writes are accepted during the pass.
// Stall: the result sits in an output register; while out_tready is low the
// next item is still accepted and processed, and waits before its final step
// until the output register is free.
module lfo_flanger
  import lfl_pkg::*;
#(
  parameter int BUFFER_LEN         = BUFFER_LEN_DEF,
  parameter int SINE_TABLE_ENTRIES = SINE_ENTRIES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]          cfg_wdata,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [SAMPLE_W-1:0]       in_tdata,   // sample_in
  input  logic                      in_tuser,   // block_start
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [SAMPLE_W+LFO_W-1:0] out_tdata   // sample_out, lfo_value
);

  localparam int PW = $clog2(BUFFER_LEN);
  localparam int IW = $clog2(SINE_TABLE_ENTRIES);
  localparam int NW = $clog2(SINE_TABLE_ENTRIES + 1);
  localparam logic [PW-1:0] LAST_ADDR = PW'(BUFFER_LEN - 1);

  state_t state_r, state_nxt;

  logic [STEP_W-1:0] phase_step_r;
  logic [MAXD_W-1:0] max_delay_r;
  logic [FB_W-1:0]   feedback_r;
  logic [MIX_W-1:0]  mix_r;
  logic [WAVE_W-1:0] waveform_r;

  logic [SAMPLE_W-1:0]       x_r;
  logic [PHASE_W-1:0]        phase_r, phase_nxt;
  logic [IW-1:0]             sin_idx_r, sin_idx_nxt;
  logic [PHASE_W+NW-1:0]     sin_prod;
  logic [LFO_W-1:0]          lfo_r, lfo_nxt;
  logic [PHASE_W-1:0]        tri_dist;
  logic [LFO_W:0]            tri_v;
  logic [PW-1:0]             wp_r, wp_nxt;
  logic [PW-1:0]             rd_addr_r, rd_addr_nxt;
  logic [PW-1:0]             delay;
  logic [SAMPLE_W-1:0]       rdata_r;
  logic [SAMPLE_W-1:0]       ram_wdata;
  logic                      out_valid_r, out_valid_nxt;
  logic [SAMPLE_W+LFO_W-1:0] out_data_r;

  logic [MAXD_W-1:0] maxd_c;
  logic [FB_W-1:0]   fb_c;
  logic [MIX_W-1:0]  m_c;

  logic [HI_W-1:0]  mac_hi_r, mac_hi_nxt;
  logic [MIX_W-1:0] mac_lo_r, mac_lo_nxt;
  logic [MIX_W-1:0] mac_b1_r, mac_b1_nxt;
  logic [MIX_W-1:0] mac_b2_r, mac_b2_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [OPW-1:0]   mac_a1;
  logic [OPW-1:0]   mac_a2;
  logic [SUM_W-1:0] mac_sum;
  logic [SUM_W-1:0] fb_sum;
  logic [SUM_W-1:0] mix_round;
  logic [SAMPLE_W-1:0] fb_sat;
  logic [SAMPLE_W-1:0] mix_sat;

  logic in_accept;
  logic ram_we;
  logic wp_adv;
  logic idx_load;
  logic lfo_load;
  logic rd_load;
  logic rdata_load;
  logic mac_en;
  logic mac_load_dly;
  logic mac_load_fb;
  logic mac_load_mix;
  logic out_load;

  logic [SAMPLE_W-1:0] ring [BUFFER_LEN];
  logic [LFO_W-1:0]    sine_rom [SINE_TABLE_ENTRIES];

  for (genvar k = 0; k < SINE_TABLE_ENTRIES; k++) begin : g_sine
    localparam logic [PHASE_W-1:0] TURN = PHASE_W'((64'(k) << PHASE_W) / SINE_TABLE_ENTRIES);
    assign sine_rom[k] = sine_of_turn(TURN);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:   if (wp_r == LAST_ADDR) state_nxt = ST_IDLE;
      ST_IDLE:    if (in_tvalid) state_nxt = ST_LFO_IDX;
      ST_LFO_IDX: state_nxt = ST_LFO_VAL;
      ST_LFO_VAL: state_nxt = ST_DLY;
      ST_DLY:     if (cnt_r == CNT_W'(LFO_W - 1)) state_nxt = ST_ADDR;
      ST_ADDR:    state_nxt = ST_RD;
      ST_RD:      state_nxt = ST_FB;
      ST_FB:      if (cnt_r == CNT_W'(FB_W - 1)) state_nxt = ST_WR;
      ST_WR:      state_nxt = ST_MIX;
      ST_MIX:     if (cnt_r == CNT_W'(MIX_W - 1)) state_nxt = ST_DONE;
      ST_DONE:    if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default:    state_nxt = ST_CLEAR;
    endcase
  end

  // control decode
  always_comb begin
    in_tready    = 1'b0;
    ram_we       = 1'b0;
    wp_adv       = 1'b0;
    idx_load     = 1'b0;
    lfo_load     = 1'b0;
    rd_load      = 1'b0;
    rdata_load   = 1'b0;
    mac_en       = 1'b0;
    mac_load_dly = 1'b0;
    mac_load_fb  = 1'b0;
    mac_load_mix = 1'b0;
    out_load     = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        ram_we = 1'b1;
        wp_adv = 1'b1;
      end
      ST_IDLE:    in_tready = 1'b1;
      ST_LFO_IDX: idx_load = 1'b1;
      ST_LFO_VAL: begin
        lfo_load     = 1'b1;
        mac_load_dly = 1'b1;
      end
      ST_DLY:  mac_en = 1'b1;
      ST_ADDR: rd_load = 1'b1;
      ST_RD: begin
        rdata_load  = 1'b1;
        mac_load_fb = 1'b1;
      end
      ST_FB: mac_en = 1'b1;
      ST_WR: begin
        ram_we       = 1'b1;
        wp_adv       = 1'b1;
        mac_load_mix = 1'b1;
      end
      ST_MIX:  mac_en = 1'b1;
      ST_DONE: out_load = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  assign in_accept = in_tvalid && in_tready;

  // datapath
  always_comb begin
    maxd_c = max_delay_r;
    if (max_delay_r == '0) begin
      maxd_c = MAXD_W'(1);
    end else if (32'(max_delay_r) > 32'(BUFFER_LEN - 1)) begin
      maxd_c = MAXD_W'(BUFFER_LEN - 1);
    end
    fb_c = (feedback_r > FB_MAX) ? FB_MAX : feedback_r;
    m_c  = (mix_r > MIX_ONE) ? MIX_ONE : mix_r;

    sin_prod    = (PHASE_W + NW)'(phase_r) * (PHASE_W + NW)'(SINE_TABLE_ENTRIES);
    sin_idx_nxt = idx_load ? sin_prod[PHASE_W +: IW] : sin_idx_r;

    tri_dist = phase_r[PHASE_W-1] ? (PHASE_W'(0) - phase_r) : phase_r;
    tri_v    = tri_dist[PHASE_W-1:LFO_W-1];
    case (waveform_r)
      WAVE_SINE: lfo_nxt = sine_rom[sin_idx_r];
      WAVE_TRI:  lfo_nxt = tri_v[LFO_W] ? {1'b0, {(LFO_W-1){1'b1}}}
                                        : {~tri_v[LFO_W-1], tri_v[LFO_W-2:0]};
      default:   lfo_nxt = phase_r[PHASE_W-1 -: LFO_W];
    endcase

    mac_a1 = (state_r == ST_DLY) ? {{(OPW-MAXD_W){1'b0}}, maxd_c}
                                 : {rdata_r[SAMPLE_W-1], rdata_r};
    mac_a2 = {x_r[SAMPLE_W-1], x_r};
    mac_sum = {mac_hi_r[HI_W-1], mac_hi_r}
            + (mac_b1_r[0] ? {{2{mac_a1[OPW-1]}}, mac_a1} : SUM_W'(0))
            + (mac_b2_r[0] ? {{2{mac_a2[OPW-1]}}, mac_a2} : SUM_W'(0));

    mac_hi_nxt = mac_hi_r;
    mac_lo_nxt = mac_lo_r;
    mac_b1_nxt = mac_b1_r;
    mac_b2_nxt = mac_b2_r;
    cnt_nxt    = cnt_r;
    if (mac_load_dly) begin
      mac_hi_nxt = '0;
      mac_b1_nxt = MIX_W'({~lfo_nxt[LFO_W-1], lfo_nxt[LFO_W-2:0]});
      mac_b2_nxt = '0;
      cnt_nxt    = '0;
    end else if (mac_load_fb) begin
      mac_hi_nxt = '0;
      mac_b1_nxt = MIX_W'(fb_c);
      mac_b2_nxt = '0;
      cnt_nxt    = '0;
    end else if (mac_load_mix) begin
      mac_hi_nxt = '0;
      mac_b1_nxt = m_c;
      mac_b2_nxt = MIX_ONE - m_c;
      cnt_nxt    = '0;
    end else if (mac_en) begin
      mac_hi_nxt = mac_sum[SUM_W-1:1];
      mac_lo_nxt = {mac_sum[0], mac_lo_r[MIX_W-1:1]};
      mac_b1_nxt = mac_b1_r >> 1;
      mac_b2_nxt = mac_b2_r >> 1;
      cnt_nxt    = cnt_r + 1'b1;
    end

    // ring read address: write pointer minus delay, modulo the ring length
    delay = mac_hi_r[PW-1:0];
    if (wp_r >= delay) begin
      rd_addr_nxt = wp_r - delay;
    end else begin
      rd_addr_nxt = PW'((PW+1)'(wp_r) + (PW+1)'(BUFFER_LEN) - (PW+1)'(delay));
    end
    if (!rd_load) begin
      rd_addr_nxt = rd_addr_r;
    end

    // product rounding: add half an LSB of the Q0.16 feedback gain or the Q1.16 mix gain
    fb_sum    = {{(SUM_W-SAMPLE_W){x_r[SAMPLE_W-1]}}, x_r}
              + {mac_hi_r[HI_W-1], mac_hi_r}
              + SUM_W'(mac_lo_r[MIX_W-1]);
    fb_sat    = sat_sample(fb_sum);
    mix_round = {mac_hi_r, mac_lo_r[MIX_W-1]} + SUM_W'(mac_lo_r[MIX_W-2]);
    mix_sat   = sat_sample(mix_round);

    ram_wdata = (state_r == ST_CLEAR) ? '0 : fb_sat;

    wp_nxt = wp_r;
    if (wp_adv) begin
      wp_nxt = (wp_r == LAST_ADDR) ? '0 : wp_r + 1'b1;
    end

    phase_nxt = phase_r;
    if (in_accept && in_tuser) begin
      phase_nxt = '0;
    end else if (out_load) begin
      phase_nxt = phase_r + PHASE_W'(phase_step_r);
    end

    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      wp_r         <= '0;
      phase_r      <= '0;
      out_valid_r  <= 1'b0;
      phase_step_r <= '0;
      max_delay_r  <= MAXD_W'(1);
      feedback_r   <= '0;
      mix_r        <= '0;
      waveform_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_PHASE_STEP: phase_step_r <= cfg_wdata[STEP_W-1:0];
          CFG_MAX_DELAY:  max_delay_r  <= cfg_wdata[MAXD_W-1:0];
          CFG_FEEDBACK:   feedback_r   <= cfg_wdata[FB_W-1:0];
          CFG_MIX:        mix_r        <= cfg_wdata[MIX_W-1:0];
          CFG_WAVEFORM:   waveform_r   <= cfg_wdata[WAVE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      x_r <= in_tdata;
    end
    if (lfo_load) begin
      lfo_r <= lfo_nxt;
    end
    if (out_load) begin
      out_data_r <= {lfo_r, mix_sat};
    end
    sin_idx_r <= sin_idx_nxt;
    rd_addr_r <= rd_addr_nxt;
    mac_hi_r  <= mac_hi_nxt;
    mac_lo_r  <= mac_lo_nxt;
    mac_b1_r  <= mac_b1_nxt;
    mac_b2_r  <= mac_b2_nxt;
    cnt_r     <= cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      ring[wp_r] <= ram_wdata;
    end
    if (rdata_load) begin
      rdata_r <= ring[rd_addr_r];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> !in_tready)
    else $error("second item accepted while one is in flight");

  a_wp_range: assert property (@(posedge clk) disable iff (!rst_n)
    (PW+1)'(wp_r) < (PW+1)'(BUFFER_LEN))
    else $error("write pointer outside ring");

  a_rd_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD) |-> ((PW+1)'(rd_addr_r) < (PW+1)'(BUFFER_LEN)))
    else $error("read address outside ring");

  a_delay_max: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ADDR) |-> (32'(delay) < 32'(maxd_c)) && (mac_hi_r[HI_W-1:PW] == '0))
    else $error("modulated delay not below max_delay");

  a_wp_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WR) |=>
      (wp_r == (($past(wp_r) == LAST_ADDR) ? PW'(0) : PW'($past(wp_r) + 1'b1))))
    else $error("write pointer did not advance by one item");

endmodule
